>>> rtl/cta_pkg.sv
// ----------------------------------------------------------------------------
// cta_pkg
// Shared types and constants of the calorimeter tower accumulator.
// ----------------------------------------------------------------------------
package cta_pkg;

  // Field and store widths.
  localparam int unsigned E_W     = 24;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned BARY_W  = 13;
  localparam int unsigned SLOT    = 32;
  localparam int unsigned NUM_SUB = 3;
  localparam int unsigned DEPTH   = NUM_SUB * SLOT;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  // Saturation limits.
  localparam logic [E_W-1:0]    E_MAX    = {E_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [BARY_W-1:0] BARY_MAX = 13'd7936;

  // Valid subdetector numbers.
  localparam logic [2:0] SUB_FIRST = 3'd3;
  localparam logic [2:0] SUB_LAST  = 3'd5;

  // Default layer counts.
  localparam int unsigned FRONT_LAYERS_DEF = 31;
  localparam int unsigned BACK_LAYERS_DEF  = 13;

  // Serial divider widths: dividend, divisor, quotient.
  localparam int unsigned DIV_NW = 45;
  localparam int unsigned DIV_DW = 25;
  localparam int unsigned DIV_QW = 18;

  typedef enum logic [1:0] {
    OP_ADD_HIT = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [E_W-1:0]   energy;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clear;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
  } store_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DIV_QW-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/cta_if.sv
// ----------------------------------------------------------------------------
// cta_if
// Valid/ready channels of the tower accumulator: input words and result words.
// ----------------------------------------------------------------------------
interface cta_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        hit_energy;
  logic signed [14:0] hit_eta;
  logic signed [15:0] hit_phi;
  logic signed [15:0] hit_x;
  logic signed [15:0] hit_y;
  logic [4:0]         layer_index;
  logic [2:0]         subdetector;
  logic [4:0]         first_layer;
  logic [4:0]         last_layer;

  modport source (output valid, op, hit_energy, hit_eta, hit_phi, hit_x, hit_y,
                  layer_index, subdetector, first_layer, last_layer, input ready);
  modport sink (input valid, op, hit_energy, hit_eta, hit_phi, hit_x, hit_y,
                layer_index, subdetector, first_layer, last_layer, output ready);
endinterface

interface cta_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [23:0]        total_energy;
  logic signed [14:0] mean_eta;
  logic signed [15:0] mean_phi;
  logic signed [15:0] mean_x;
  logic signed [15:0] mean_y;
  logic [23:0]        range_energy;
  logic [4:0]         active_layers;
  logic [12:0]        barycenter;

  modport source (output valid, status, total_energy, mean_eta, mean_phi, mean_x,
                  mean_y, range_energy, active_layers, barycenter, input ready);
  modport sink (input valid, status, total_energy, mean_eta, mean_phi, mean_x,
                mean_y, range_energy, active_layers, barycenter, output ready);
endinterface

>>> rtl/cta_store.sv
// ----------------------------------------------------------------------------
// cta_store
// Layer store: energy and hit count per subdetector and layer, registered read.
// ----------------------------------------------------------------------------
module cta_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cta_pkg::store_req_t req_i,
  output cta_pkg::entry_t     rdata_o
);

  cta_pkg::entry_t               mem [cta_pkg::DEPTH];
  logic [cta_pkg::DEPTH-1:0]     vld_q;
  cta_pkg::entry_t               rdata_q;
  logic                          rvld_q;

  // Memory array, no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // Entry valid bits: an entry never written since clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/cta_div.sv
// ----------------------------------------------------------------------------
// cta_div
// Restoring divider, one quotient bit per cycle, with an overflow flag.
// ----------------------------------------------------------------------------
module cta_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cta_pkg::div_req_t req_i,
  output cta_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW = cta_pkg::DIV_QW;
  localparam int unsigned NW = cta_pkg::DIV_NW;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [NW-1:0] rem_q, dsh_q, rem_sub;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, ovf_q, ge;

  // One compare and subtract per cycle.
  always_comb begin
    ge      = rem_q >= dsh_q;
    rem_sub = rem_q - dsh_q;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dsh_q <= NW'(req_i.divisor) << (QW - 1);
      quo_q <= '0;
      ovf_q <= req_i.dividend >= (NW'(req_i.divisor) << QW);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_sub;
      end
      quo_q <= {quo_q[QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= CW'(QW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quo_q;

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider count ran out while busy");
`endif

endmodule

>>> rtl/calorimeter_tower_accumulator_top.sv
// ----------------------------------------------------------------------------
// calorimeter_tower_accumulator_top
// Energy-weighted tower centroid with a per-layer energy store and queries.
//
//   channel | dir | handshake     | word
//   in_i    | in  | valid / ready | op, hit fields, layer, subdetector, range
//   out_o   | out | valid / ready | status, tower sums and means, query fields
//
// One word at a time. An add-hit runs decode, store read and write, then per
// mean one multiply, one add and one division; decode and store update only
// if the tower stays empty. A query makes one store read per layer and one
// division, with no division when the tower has no energy. Clear and rejected
// words go from decode straight to the output register.
// Reset and clear empty the store at once through per-entry valid bits.
// A new word is taken while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module calorimeter_tower_accumulator_top #(
  parameter int unsigned FRONT_LAYERS = cta_pkg::FRONT_LAYERS_DEF,
  parameter int unsigned BACK_LAYERS  = cta_pkg::BACK_LAYERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cta_in_if.sink    in_i,
  cta_out_if.source out_o
);

  localparam logic [5:0] N_FRONT = 6'(FRONT_LAYERS);
  localparam logic [5:0] N_BACK  = 6'(BACK_LAYERS);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DEC  = 11'b000_0000_0010,
    S_HRD  = 11'b000_0000_0100,
    S_HWR  = 11'b000_0000_1000,
    S_MUL  = 11'b000_0001_0000,
    S_ADD  = 11'b000_0010_0000,
    S_DIV  = 11'b000_0100_0000,
    S_QRD  = 11'b000_1000_0000,
    S_BST  = 11'b001_0000_0000,
    S_BWT  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e state_q;

  // Latched input word.
  logic [1:0]         op_q;
  logic [15:0]        e_q;
  logic signed [14:0] eta_q;
  logic signed [15:0] phi_q, x_q, y_q;
  logic [4:0]         lay_q, l1_q, l2_q;
  logic [2:0]         sub_q;

  // Tower state.
  logic [23:0]        energy_q;
  logic signed [15:0] eta_m_q, phi_m_q, x_m_q, y_m_q;

  // Work registers.
  logic [24:0]        d_q;
  logic [1:0]         k_q;
  logic signed [43:0] prod_a_q, prod_b_q;
  logic               neg_q;
  logic signed [15:0] res_q [3];
  logic [5:0]         cnt_q;
  logic               acc_vld_q;
  logic [4:0]         acc_l_q;
  logic [23:0]        range_q;
  logic [5:0]         act_q;
  logic [33:0]        wsum_q;
  logic               status_q;
  logic [12:0]        bary_q;

  // Output register.
  logic               out_vld_q;
  logic               o_status_q;
  logic [23:0]        o_energy_q, o_range_q;
  logic signed [14:0] o_eta_q;
  logic signed [15:0] o_phi_q, o_x_q, o_y_q;
  logic [4:0]         o_active_q;
  logic [12:0]        o_bary_q;

  cta_pkg::store_req_t st_req;
  cta_pkg::entry_t     st_rdata;
  cta_pkg::div_req_t   div_req;
  cta_pkg::div_rsp_t   div_rsp;

  logic               accept, load;
  logic               sub_ok, hit_ok, qry_ok;
  logic [1:0]         s_idx;
  logic [5:0]         n_lay;
  logic signed [17:0] mean_sel, v_sel, unw;
  logic signed [15:0] dphi;
  logic signed [43:0] op_m, op_v, op_eo, op_eh, num;
  logic [43:0]        mag;
  logic [24:0]        le_sum, rs_sum, d_d;
  logic [18:0]        qs;
  logic [12:0]        bq;
  logic               in_rng, last_l;

  cta_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .rdata_o(st_rdata)
  );

  cta_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load       = (state_q == S_DONE) && (!out_vld_q || out_o.ready);

  // Decode of subdetector and layer checks.
  always_comb begin
    sub_ok = sub_q inside {[cta_pkg::SUB_FIRST:cta_pkg::SUB_LAST]};
    s_idx  = sub_ok ? 2'(sub_q - cta_pkg::SUB_FIRST) : 2'd0;
    n_lay  = (s_idx == 2'd0) ? N_FRONT : N_BACK;
    hit_ok = sub_ok && ({1'b0, lay_q} < n_lay);
    qry_ok = sub_ok && ({1'b0, l1_q} < n_lay) && ({1'b0, l2_q} < n_lay);
  end

  // Mean and value of the field being blended, phi unwrapped around its mean.
  always_comb begin
    dphi = phi_q - phi_m_q;
    unw  = {{2{phi_m_q[15]}}, phi_m_q} + {{2{dphi[15]}}, dphi};
    case (k_q)
      2'd0: begin
        mean_sel = {{2{eta_m_q[15]}}, eta_m_q};
        v_sel    = {{3{eta_q[14]}}, eta_q};
      end
      2'd1: begin
        mean_sel = {{2{phi_m_q[15]}}, phi_m_q};
        v_sel    = unw;
      end
      2'd2: begin
        mean_sel = {{2{x_m_q[15]}}, x_m_q};
        v_sel    = {{2{x_q[15]}}, x_q};
      end
      default: begin
        mean_sel = {{2{y_m_q[15]}}, y_m_q};
        v_sel    = {{2{y_q[15]}}, y_q};
      end
    endcase
    op_m  = {{26{mean_sel[17]}}, mean_sel};
    op_v  = {{26{v_sel[17]}}, v_sel};
    op_eo = {20'd0, energy_q};
    op_eh = {28'd0, e_q};
    num   = prod_a_q + prod_b_q;
    mag   = num[43] ? 44'(-num) : 44'(num);
    qs    = neg_q ? 19'(-{1'b0, div_rsp.quot}) : {1'b0, div_rsp.quot};
    bq    = (div_rsp.ovf || (div_rsp.quot > 18'(cta_pkg::BARY_MAX)))
            ? cta_pkg::BARY_MAX : div_rsp.quot[12:0];
  end

  // Store update and query accumulation terms.
  always_comb begin
    le_sum = {1'b0, st_rdata.energy} + 25'(e_q);
    d_d    = {1'b0, energy_q} + 25'(e_q);
    in_rng = (acc_l_q >= l1_q) && (acc_l_q <= l2_q);
    rs_sum = {1'b0, range_q} + {1'b0, st_rdata.energy};
    last_l = ({1'b0, acc_l_q} == (n_lay - 6'd1));
  end

  // Store and divider requests.
  always_comb begin
    st_req      = '0;
    div_req     = '0;
    st_req.clear = (state_q == S_DEC) && (op_q == cta_pkg::OP_CLEAR);
    case (state_q)
      S_HRD: begin
        st_req.rd_en = 1'b1;
        st_req.raddr = {s_idx, lay_q};
      end
      S_HWR: begin
        st_req.wr_en         = 1'b1;
        st_req.waddr         = {s_idx, lay_q};
        st_req.wdata.energy  = le_sum[24] ? cta_pkg::E_MAX : le_sum[23:0];
        st_req.wdata.cnt     = (st_rdata.cnt == cta_pkg::CNT_MAX)
                               ? st_rdata.cnt : st_rdata.cnt + 1'b1;
      end
      S_QRD: begin
        st_req.rd_en = cnt_q < n_lay;
        st_req.raddr = {s_idx, cnt_q[4:0]};
      end
      S_ADD: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, mag} + 45'(d_q >> 1);
        div_req.divisor  = d_q;
      end
      S_BST: begin
        div_req.start    = energy_q != '0;
        div_req.dividend = {3'd0, wsum_q, 8'd0} + 45'(energy_q >> 1);
        div_req.divisor  = {1'b0, energy_q};
      end
      default: begin
      end
    endcase
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.op;
      e_q   <= in_i.hit_energy;
      eta_q <= in_i.hit_eta;
      phi_q <= in_i.hit_phi;
      x_q   <= in_i.hit_x;
      y_q   <= in_i.hit_y;
      lay_q <= in_i.layer_index;
      sub_q <= in_i.subdetector;
      l1_q  <= in_i.first_layer;
      l2_q  <= in_i.last_layer;
    end
  end

  // Products of one blend, sign, energy sum and per-mean results, and the registered store read index.
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_a_q <= op_m * op_eo;
      prod_b_q <= op_v * op_eh;
    end
    if (state_q == S_ADD) begin
      neg_q <= num[43];
    end
    if (state_q == S_HWR) begin
      d_q <= d_d;
    end
    if ((state_q == S_DIV) && div_rsp.done && (k_q != 2'd3)) begin
      res_q[k_q] <= qs[15:0];
    end
    acc_l_q <= cnt_q[4:0];
  end

  // Sequencer and tower state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      energy_q  <= '0;
      eta_m_q   <= '0;
      phi_m_q   <= '0;
      x_m_q     <= '0;
      y_m_q     <= '0;
      k_q       <= '0;
      cnt_q     <= '0;
      acc_vld_q <= 1'b0;
      range_q   <= '0;
      act_q     <= '0;
      wsum_q    <= '0;
      status_q  <= 1'b0;
      bary_q    <= '0;
    end else begin
      acc_vld_q <= st_req.rd_en && (state_q == S_QRD);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= 1'b0;
            range_q  <= '0;
            act_q    <= '0;
            wsum_q   <= '0;
            bary_q   <= '0;
            k_q      <= '0;
            cnt_q    <= '0;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          case (op_q)
            cta_pkg::OP_ADD_HIT: begin
              if (hit_ok) begin
                state_q <= S_HRD;
              end else begin
                status_q <= 1'b1;
                state_q  <= S_DONE;
              end
            end
            cta_pkg::OP_CLEAR: begin
              energy_q <= '0;
              eta_m_q  <= '0;
              phi_m_q  <= '0;
              x_m_q    <= '0;
              y_m_q    <= '0;
              state_q  <= S_DONE;
            end
            cta_pkg::OP_QUERY: begin
              if (qry_ok) begin
                state_q <= S_QRD;
              end else begin
                status_q <= 1'b1;
                state_q  <= S_DONE;
              end
            end
            default: begin
              status_q <= 1'b1;
              state_q  <= S_DONE;
            end
          endcase
        end
        S_HRD: begin
          state_q <= S_HWR;
        end
        S_HWR: begin
          state_q <= (d_d == '0) ? S_DONE : S_MUL;
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (k_q == 2'd3) begin
              eta_m_q  <= res_q[0];
              phi_m_q  <= res_q[1];
              x_m_q    <= res_q[2];
              y_m_q    <= qs[15:0];
              energy_q <= d_q[24] ? cta_pkg::E_MAX : d_q[23:0];
              state_q  <= S_DONE;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_MUL;
            end
          end
        end
        S_QRD: begin
          if (st_req.rd_en) begin
            cnt_q <= cnt_q + 6'd1;
          end
          if (acc_vld_q) begin
            if (in_rng) begin
              range_q <= rs_sum[24] ? cta_pkg::E_MAX : rs_sum[23:0];
            end
            if (st_rdata.energy != '0) begin
              act_q <= act_q + 6'd1;
            end
            wsum_q <= wsum_q + 34'(acc_l_q * st_rdata.energy);
            if (last_l) begin
              state_q <= S_BST;
            end
          end
        end
        S_BST: begin
          state_q <= (energy_q == '0) ? S_DONE : S_BWT;
        end
        S_BWT: begin
          if (div_rsp.done) begin
            bary_q  <= bq;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the result is finished and the slot is free or being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_status_q <= status_q;
      o_energy_q <= energy_q;
      o_eta_q    <= eta_m_q[14:0];
      o_phi_q    <= phi_m_q;
      o_x_q      <= x_m_q;
      o_y_q      <= y_m_q;
      o_range_q  <= range_q;
      o_active_q <= (act_q > 6'd31) ? 5'd31 : act_q[4:0];
      o_bary_q   <= bary_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = o_status_q;
  assign out_o.total_energy  = o_energy_q;
  assign out_o.mean_eta      = o_eta_q;
  assign out_o.mean_phi      = o_phi_q;
  assign out_o.mean_x        = o_x_q;
  assign out_o.mean_y        = o_y_q;
  assign out_o.range_energy  = o_range_q;
  assign out_o.active_layers = o_active_q;
  assign out_o.barycenter    = o_bary_q;

`ifndef NO_ASSERTIONS
  a_div_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV || state_q == S_BWT))
    else $error("divider result arrived while not awaited");
  a_energy_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_DEC && op_q == cta_pkg::OP_CLEAR) |=> energy_q >= $past(energy_q))
    else $error("tower energy dropped without clear");
  a_bary_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bary_q <= cta_pkg::BARY_MAX) else $error("barycenter above limit");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DEC) else $error("accepted word not decoded");
`endif

endmodule

>>> dv/tb_calorimeter_tower_accumulator_top.sv
// ----------------------------------------------------------------------------
// tb_calorimeter_tower_accumulator_top
// Self-checking bench for the tower accumulator. Hit, clear and query words
// are driven with random gaps. A model of the tower inside the bench predicts
// each result word, and the monitor compares every field in order.
// ----------------------------------------------------------------------------
module tb_calorimeter_tower_accumulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NFRONT = cta_pkg::FRONT_LAYERS_DEF;
  localparam int unsigned NBACK  = cta_pkg::BACK_LAYERS_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        hit_energy;
    logic signed [14:0] hit_eta;
    logic signed [15:0] hit_phi;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic [4:0]         layer_index;
    logic [2:0]         subdetector;
    logic [4:0]         first_layer;
    logic [4:0]         last_layer;
  } hit_word_t;

  typedef struct packed {
    logic               status;
    logic [23:0]        total_energy;
    logic signed [14:0] mean_eta;
    logic signed [15:0] mean_phi;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic [23:0]        range_energy;
    logic [4:0]         active_layers;
    logic [12:0]        barycenter;
  } tower_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cta_in_if  in_ch ();
  cta_out_if out_ch ();

  calorimeter_tower_accumulator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // Tower model state.
  longint     tw_energy;
  longint     m_eta, m_phi, m_x, m_y;
  longint     m_store [96];
  hit_word_t   pending_q [$];
  tower_word_t tower_q [$];
  int         errors = 0;
  int         n_hits = 0, n_queries = 0, n_results = 0;
  bit         quiet = 1'b0;
  bit         stim_done = 1'b0;

  function automatic longint wrap_turn(longint v);
    logic [15:0] t;
    t = v[15:0];
    return longint'($signed(t));
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic void model_clear();
    tw_energy = 0; m_eta = 0; m_phi = 0; m_x = 0; m_y = 0;
    foreach (m_store[i]) m_store[i] = 0;
  endfunction

  // Append one word to the stimulus queue.
  function automatic void queue_word(hit_word_t w);
    pending_q = {pending_q, w};
  endfunction

  // Predict the result word of one accepted input word.
  function automatic tower_word_t predict_tower(hit_word_t w);
    tower_word_t r;
    longint d, e, unw, sum, wsum, b;
    int n, s, act;
    bit sub_ok;
    r = '0;
    e = w.hit_energy;
    sub_ok = (w.subdetector >= cta_pkg::SUB_FIRST && w.subdetector <= cta_pkg::SUB_LAST);
    s = sub_ok ? w.subdetector - 3 : 0;
    n = (s == 0) ? NFRONT : NBACK;
    case (w.op)
      cta_pkg::OP_ADD_HIT: begin
        if (!sub_ok || w.layer_index >= n) begin
          r.status = 1'b1;
        end else begin
          n_hits++;
          d = tw_energy + e;
          if (d > 0) begin
            unw = m_phi + wrap_turn(longint'(w.hit_phi) - m_phi);
            m_eta = round_div(m_eta * tw_energy + longint'(w.hit_eta) * e, d);
            m_phi = wrap_turn(round_div(m_phi * tw_energy + unw * e, d));
            m_x = round_div(m_x * tw_energy + longint'(w.hit_x) * e, d);
            m_y = round_div(m_y * tw_energy + longint'(w.hit_y) * e, d);
          end
          tw_energy = (d > cta_pkg::E_MAX) ? cta_pkg::E_MAX : d;
          sum = m_store[s*32 + w.layer_index] + e;
          m_store[s*32 + w.layer_index] = (sum > cta_pkg::E_MAX) ? cta_pkg::E_MAX : sum;
        end
      end
      cta_pkg::OP_CLEAR: model_clear();
      cta_pkg::OP_QUERY: begin
        if (!sub_ok || w.first_layer >= n || w.last_layer >= n) begin
          r.status = 1'b1;
        end else begin
          n_queries++;
          sum = 0; wsum = 0; act = 0;
          for (int l = 0; l < n; l++) begin
            if (l >= w.first_layer && l <= w.last_layer) begin
              sum += m_store[s*32 + l];
              if (sum > cta_pkg::E_MAX) sum = cta_pkg::E_MAX;
            end
            if (m_store[s*32 + l] != 0) act++;
            wsum += l * m_store[s*32 + l];
          end
          r.range_energy = sum;
          r.active_layers = (act > 31) ? 31 : act;
          if (tw_energy != 0) begin
            b = (wsum * 256 + tw_energy / 2) / tw_energy;
            r.barycenter = (b > cta_pkg::BARY_MAX) ? cta_pkg::BARY_MAX : b;
          end
        end
      end
      default: r.status = 1'b1;
    endcase
    r.total_energy = tw_energy;
    r.mean_eta = m_eta;
    r.mean_phi = m_phi;
    r.mean_x = m_x;
    r.mean_y = m_y;
    return r;
  endfunction

  // Driver: present pending words, with random gaps outside quiet stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        hit_word_t   taken;
        tower_word_t pred;
        taken = pending_q.pop_front();
        pred = predict_tower(taken);
        tower_q = {tower_q, pred};
      end
      if ((!in_ch.valid || in_ch.ready) || !in_ch.valid) begin
        if (in_ch.valid && !in_ch.ready) begin
          // Hold the word until it is taken.
        end else if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
          in_ch.valid <= 1'b1;
          {in_ch.op, in_ch.hit_energy, in_ch.hit_eta, in_ch.hit_phi, in_ch.hit_x,
           in_ch.hit_y, in_ch.layer_index, in_ch.subdetector, in_ch.first_layer,
           in_ch.last_layer} <= pending_q[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        tower_word_t exp_w;
        n_results++;
        if (tower_q.size() == 0) begin
          $error("result word with no prediction waiting");
          errors++;
        end else begin
          exp_w = tower_q.pop_front();
          if (out_ch.status !== exp_w.status) begin
            $error("status exp %0d got %0d", exp_w.status, out_ch.status); errors++;
          end
          if (out_ch.total_energy !== exp_w.total_energy) begin
            $error("total_energy exp %0d got %0d", exp_w.total_energy,
                   out_ch.total_energy); errors++;
          end
          if (out_ch.mean_eta !== exp_w.mean_eta) begin
            $error("mean_eta exp %0d got %0d", exp_w.mean_eta, out_ch.mean_eta); errors++;
          end
          if (out_ch.mean_phi !== exp_w.mean_phi) begin
            $error("mean_phi exp %0d got %0d", exp_w.mean_phi, out_ch.mean_phi); errors++;
          end
          if (out_ch.mean_x !== exp_w.mean_x) begin
            $error("mean_x exp %0d got %0d", exp_w.mean_x, out_ch.mean_x); errors++;
          end
          if (out_ch.mean_y !== exp_w.mean_y) begin
            $error("mean_y exp %0d got %0d", exp_w.mean_y, out_ch.mean_y); errors++;
          end
          if (out_ch.range_energy !== exp_w.range_energy) begin
            $error("range_energy exp %0d got %0d", exp_w.range_energy,
                   out_ch.range_energy); errors++;
          end
          if (out_ch.active_layers !== exp_w.active_layers) begin
            $error("active_layers exp %0d got %0d", exp_w.active_layers,
                   out_ch.active_layers); errors++;
          end
          if (out_ch.barycenter !== exp_w.barycenter) begin
            $error("barycenter exp %0d got %0d", exp_w.barycenter,
                   out_ch.barycenter); errors++;
          end
        end
      end
      out_ch.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // Watchdog on cycles without any accepted word or result word.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else if (!stim_done || tower_q.size() > 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", tower_q.size());
      $display("** calorimeter_tower_accumulator_top: FAILED **");
      $finish;
    end
  end

  // Fully random input word, all fields included.
  function automatic hit_word_t rand_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(hit_word_t)-1:0];
  endfunction

  function automatic hit_word_t make_hit(logic [15:0] e, logic [2:0] sub, logic [4:0] lay);
    hit_word_t w;
    w = rand_word();
    w.op = cta_pkg::OP_ADD_HIT;
    w.hit_energy = e;
    w.subdetector = sub;
    w.layer_index = lay;
    return w;
  endfunction

  function automatic hit_word_t make_query(logic [2:0] sub, logic [4:0] f, logic [4:0] l);
    hit_word_t w;
    w = rand_word();
    w.op = cta_pkg::OP_QUERY;
    w.subdetector = sub;
    w.first_layer = f;
    w.last_layer = l;
    return w;
  endfunction

  function automatic logic [4:0] rand_layer(logic [2:0] sub);
    return (sub == cta_pkg::SUB_FIRST) ? 5'($urandom_range(NFRONT - 1))
                                       : 5'($urandom_range(NBACK - 1));
  endfunction

  initial begin
    hit_word_t w;
    logic [2:0] sub;
    int kind;
    model_clear();
    in_ch.op = '0; in_ch.hit_energy = '0; in_ch.hit_eta = '0; in_ch.hit_phi = '0;
    in_ch.hit_x = '0; in_ch.hit_y = '0; in_ch.layer_index = '0;
    in_ch.subdetector = '0; in_ch.first_layer = '0; in_ch.last_layer = '0;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes, rejects, zero energy, wrap and saturation.
    w = make_hit(16'd0, 3'd3, 5'd0); queue_word(w);
    w = make_hit(16'hFFFF, 3'd3, 5'd30);
    w.hit_eta = 15'sh3FFF; w.hit_phi = 16'sh7FFF; w.hit_x = 16'sh7FFF; w.hit_y = 16'sh8000;
    queue_word(w);
    w = make_hit(16'hFFFF, 3'd4, 5'd0);
    w.hit_eta = 15'sh4000; w.hit_phi = 16'sh8000; w.hit_x = 16'sh8000; w.hit_y = 16'sh7FFF;
    queue_word(w);
    queue_word(make_hit(16'd1, 3'd5, 5'd12));
    queue_word(make_hit(16'd5, 3'd4, 5'd13));
    queue_word(make_hit(16'd5, 3'd3, 5'd31));
    queue_word(make_hit(16'd5, 3'd2, 5'd1));
    queue_word(make_hit(16'd5, 3'd6, 5'd1));
    queue_word(make_hit(16'd5, 3'd7, 5'd1));
    queue_word(make_query(3'd3, 5'd0, 5'd30));
    queue_word(make_query(3'd4, 5'd12, 5'd0));
    queue_word(make_query(3'd5, 5'd0, 5'd13));
    queue_word(make_query(3'd3, 5'd31, 5'd0));
    queue_word(make_query(3'd0, 5'd0, 5'd0));
    w = make_query(3'd4, 5'd0, 5'd0); w.op = 2'd3; queue_word(w);
    w = make_hit(16'd0, 3'd3, 5'd0); w.op = cta_pkg::OP_CLEAR; queue_word(w);
    queue_word(make_query(3'd3, 5'd0, 5'd30));
    // Saturate one layer entry and the tower sum.
    for (int i = 0; i < 260; i++) queue_word(make_hit(16'hFFFF, 3'd4, 5'd7));
    queue_word(make_query(3'd4, 5'd0, 5'd12));
    w = make_hit(16'd0, 3'd3, 5'd0); w.op = cta_pkg::OP_CLEAR; queue_word(w);

    // Random part: mostly valid hits and queries, some rejects and clears.
    for (int i = 0; i < 120; i++) begin
      sub = 3'(3 + $urandom_range(2));
      kind = $urandom_range(99);
      if (kind < 60) begin
        queue_word(make_hit(16'($urandom_range(99) < 20 ? $urandom : $urandom_range(300)),
                            sub, rand_layer(sub)));
      end else if (kind < 85) begin
        queue_word(make_query(sub, rand_layer(sub), rand_layer(sub)));
      end else if (kind < 88) begin
        w = make_hit(16'd0, sub, 5'd0); w.op = cta_pkg::OP_CLEAR; queue_word(w);
      end else begin
        w = rand_word(); queue_word(w);
      end
    end

    // A long stretch in the middle of the run with no idling on either side.
    wait (pending_q.size() <= 300);
    quiet = 1'b1;
    wait (pending_q.size() <= 200);
    quiet = 1'b0;

    wait (pending_q.size() == 0);
    stim_done = 1'b1;
    wait (tower_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d accepted hits, %0d good queries, %0d result words",
             n_hits, n_queries, n_results);
    if (errors == 0) begin
      $display("** calorimeter_tower_accumulator_top: PASSED **");
    end else begin
      $display("** calorimeter_tower_accumulator_top: FAILED **");
    end
    $finish;
  end
endmodule
